/* sv/plfl_pkg.sv */
// ----------------------------------------------------------------------------
// plfl_pkg: shared types and codes for the pooled linked free list
// Operation and status codes, stream field widths, result struct.
// ----------------------------------------------------------------------------
package plfl_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned PAGE_W   = 16;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] popped;
  } res_t;

endpackage

/* sv/pooled_linked_free_list.sv */
// ----------------------------------------------------------------------------
// pooled_linked_free_list: free-page list of one buddy allocator order
// Stream front end and result register around the list sequencer.
// ----------------------------------------------------------------------------
// A singly linked list of page indexes kept in a pool of NODE_CAPACITY nodes.
// Each input item is push (op 0), pop (op 1) or delete-by-key (op 2); op 3
// does nothing and reports success. Every item yields one result item with a
// status (0 ok, 1 empty, 2 no free node, 3 key not found), the popped key (zero
// unless a pop succeeded) and the node count after the operation. Keys use the
// low KEY_WIDTH bits of page_index. The block takes one item at a time: a push
// passes from accept through S_EXEC (and S_PUSH_LINK once nodes are recycled)
// to S_DONE, a pop through S_EXEC and S_POP_RD, a delete through S_EXEC, one
// S_DEL_CMP step per node visited up to the match or the tail, and S_DEL_LINK
// when the match is not the head. The node memory gives one registered read
// per cycle, so the delete walk advances one node per cycle. A finished result
// sits in an output register, so the next item is accepted while it waits on
// m_axis_tready_i. No clearing pass is needed after reset: nodes are handed
// out from a fill mark and then from a chain of freed nodes.
// ----------------------------------------------------------------------------
module pooled_linked_free_list #(
  parameter int unsigned NODE_CAPACITY = 256,
  parameter int unsigned KEY_WIDTH     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [1:0] op, [17:2] page_index, rest zero
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [17:2] popped_index, then entry_count, zero filled
  output logic [((plfl_pkg::STATUS_W + plfl_pkg::PAGE_W + $clog2(NODE_CAPACITY+1)
                  + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int unsigned KW    = (KEY_WIDTH < plfl_pkg::PAGE_W) ? KEY_WIDTH : plfl_pkg::PAGE_W;
  localparam int unsigned CNT_W = $clog2(NODE_CAPACITY + 1);
  localparam int unsigned RES_W = plfl_pkg::STATUS_W + plfl_pkg::PAGE_W + CNT_W;
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

  // unpack the input item
  plfl_pkg::op_e           req_op;
  logic [plfl_pkg::PAGE_W-1:0] page_index;
  logic [KW-1:0]           req_key;

  assign req_op     = plfl_pkg::op_e'(s_axis_tdata_i[plfl_pkg::OP_W-1:0]);
  assign page_index = s_axis_tdata_i[plfl_pkg::OP_W +: plfl_pkg::PAGE_W];
  assign req_key    = page_index[KW-1:0];

  logic              res_valid, res_ready;
  plfl_pkg::res_t    res;
  logic [CNT_W-1:0]  res_count;

  plfl_core #(
    .NODE_CAPACITY (NODE_CAPACITY),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_op_i    (req_op),
    .req_key_i   (req_key),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .res_count_o (res_count)
  );

  // result register: loads when empty or being drained this cycle
  logic             out_valid_q;
  logic [RES_W-1:0] out_data_q;

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {res_count, res.popped, res.status};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(out_data_q);

endmodule

/* sv/plfl_core.sv */
// ----------------------------------------------------------------------------
// plfl_core: list sequencer with node memories
// Walks and relinks the list with one node read per cycle; recycles nodes.
// ----------------------------------------------------------------------------
module plfl_core #(
  parameter int unsigned NODE_CAPACITY = 256,
  parameter int unsigned KEY_WIDTH     = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    req_valid_i,
  output logic                                    req_ready_o,
  input  plfl_pkg::op_e                           req_op_i,
  input  logic [((KEY_WIDTH < plfl_pkg::PAGE_W) ?
                 KEY_WIDTH : plfl_pkg::PAGE_W)-1:0] req_key_i,
  output logic                                    res_valid_o,
  input  logic                                    res_ready_i,
  output plfl_pkg::res_t                          res_o,
  output logic [$clog2(NODE_CAPACITY+1)-1:0]      res_count_o
);

  localparam int unsigned KW    = (KEY_WIDTH < plfl_pkg::PAGE_W) ? KEY_WIDTH : plfl_pkg::PAGE_W;
  localparam int unsigned PTR_W = $clog2(NODE_CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(NODE_CAPACITY);
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODE_CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_EXEC      = 7'b0000010,
    S_PUSH_LINK = 7'b0000100,
    S_POP_RD    = 7'b0001000,
    S_DEL_CMP   = 7'b0010000,
    S_DEL_LINK  = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  plfl_pkg::op_e     op_q, op_d;
  logic [KW-1:0]     key_q, key_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  free_head_q, free_head_d;   // chain of recycled nodes
  logic [PTR_W-1:0]  wmark_q, wmark_d;           // nodes never used start here
  logic [PTR_W-1:0]  count_q, count_d;
  logic [PTR_W-1:0]  prev_q, prev_d;
  logic [PTR_W-1:0]  cur_q, cur_d;
  logic [PTR_W-1:0]  nxt_q, nxt_d;
  plfl_pkg::res_t    res_q, res_d;

  // node memories: one write port each, one shared registered read address
  logic [KW-1:0]     key_mem  [NODE_CAPACITY];
  logic [PTR_W-1:0]  next_mem [NODE_CAPACITY];
  logic [IDX_W-1:0]  rd_addr;
  logic [KW-1:0]     rd_key_q;
  logic [PTR_W-1:0]  rd_next_q;
  logic              key_we, next_we;
  logic [IDX_W-1:0]  key_wa, next_wa;
  logic [KW-1:0]     key_wd;
  logic [PTR_W-1:0]  next_wd;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    rd_key_q  <= key_mem[rd_addr];
    rd_next_q <= next_mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    head_d      = head_q;
    free_head_d = free_head_q;
    wmark_d     = wmark_q;
    count_d     = count_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    res_d       = res_q;
    rd_addr     = head_q[IDX_W-1:0];
    key_we      = 1'b0;
    key_wa      = wmark_q[IDX_W-1:0];
    key_wd      = key_q;
    next_we     = 1'b0;
    next_wa     = wmark_q[IDX_W-1:0];
    next_wd     = head_q;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_op_i;
          key_d   = req_key_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d.status = plfl_pkg::ST_OK;
        res_d.popped = '0;
        state_d      = S_DONE;
        case (op_q)
          plfl_pkg::OP_PUSH: begin
            if (count_q == NULL_PTR) begin
              res_d.status = plfl_pkg::ST_FULL;
            end else if (wmark_q != NULL_PTR) begin
              // fresh node, no read needed
              key_we  = 1'b1;
              next_we = 1'b1;
              head_d  = wmark_q;
              wmark_d = wmark_q + 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              rd_addr = free_head_q[IDX_W-1:0];
              state_d = S_PUSH_LINK;
            end
          end
          plfl_pkg::OP_POP: begin
            if (head_q == NULL_PTR) begin
              res_d.status = plfl_pkg::ST_EMPTY;
            end else begin
              state_d = S_POP_RD;
            end
          end
          plfl_pkg::OP_DELETE: begin
            res_d.status = plfl_pkg::ST_MISSING;
            if (head_q != NULL_PTR) begin
              prev_d  = NULL_PTR;
              cur_d   = head_q;
              state_d = S_DEL_CMP;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_PUSH_LINK: begin
        // reuse the head of the recycled chain
        key_we      = 1'b1;
        key_wa      = free_head_q[IDX_W-1:0];
        next_we     = 1'b1;
        next_wa     = free_head_q[IDX_W-1:0];
        next_wd     = head_q;
        head_d      = free_head_q;
        free_head_d = rd_next_q;
        count_d     = count_q + 1'b1;
        state_d     = S_DONE;
      end

      S_POP_RD: begin
        res_d.popped = plfl_pkg::PAGE_W'(rd_key_q);
        head_d       = rd_next_q;
        next_we      = 1'b1;
        next_wa      = head_q[IDX_W-1:0];
        next_wd      = free_head_q;
        free_head_d  = head_q;
        count_d      = count_q - 1'b1;
        state_d      = S_DONE;
      end

      S_DEL_CMP: begin
        // rd_*_q hold the node at cur_q
        if (rd_key_q == key_q) begin
          res_d.status = plfl_pkg::ST_OK;
          next_we      = 1'b1;
          next_wa      = cur_q[IDX_W-1:0];
          next_wd      = free_head_q;
          free_head_d  = cur_q;
          count_d      = count_q - 1'b1;
          nxt_d        = rd_next_q;
          if (prev_q == NULL_PTR) begin
            head_d  = rd_next_q;
            state_d = S_DONE;
          end else begin
            state_d = S_DEL_LINK;
          end
        end else if (rd_next_q == NULL_PTR) begin
          state_d = S_DONE;
        end else begin
          rd_addr = rd_next_q[IDX_W-1:0];
          prev_d  = cur_q;
          cur_d   = rd_next_q;
        end
      end

      S_DEL_LINK: begin
        next_we = 1'b1;
        next_wa = prev_q[IDX_W-1:0];
        next_wd = nxt_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= plfl_pkg::OP_NONE;
      head_q      <= NULL_PTR;
      free_head_q <= NULL_PTR;
      wmark_q     <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      head_q      <= head_d;
      free_head_q <= free_head_d;
      wmark_q     <= wmark_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    res_q  <= res_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign res_count_o = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NULL_PTR)
    else $error("node count above capacity");

  a_head_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == NULL_PTR) == (count_q == '0))
    else $error("head pointer and node count disagree");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_q.status == plfl_pkg::ST_FULL) |-> (count_q == NULL_PTR))
    else $error("full status with free nodes left");

  a_walk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL_CMP) |-> (cur_q != NULL_PTR && prev_q != cur_q))
    else $error("delete walk on a bad node");

endmodule
